/* rtl/sptt_pkg.sv */
// ============================================================================
// sptt_pkg
// Shared sizes, codes and word formats of the sparse polynomial term table.
// ============================================================================
package sptt_pkg;

    localparam int MAX_TERMS = 64;
    localparam int COEF_W    = 32;
    localparam int EXP_W     = 16;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_DERIV  = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_NEW       = 3'd1,
        ST_MERGED    = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CAPTURE,
        CELL_ADD_NEW,
        CELL_MERGE,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    // controller states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_CLEAR,
        S_EMPTY,
        S_READ
    } t_state;

    typedef struct packed {
        t_mode                    mode;
        logic signed [COEF_W-1:0] coefficient;
        logic [EXP_W-1:0]         exponent;
    } t_in_word;

    typedef struct packed {
        t_status                  status;
        logic                     term_valid;
        logic signed [COEF_W-1:0] coefficient_out;
        logic [EXP_W-1:0]         exponent_out;
        logic                     last;
        logic [CNT_W-1:0]         term_count;
    } t_out_word;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op                 op;
        logic signed [COEF_W-1:0] coef;
        logic [EXP_W-1:0]         exp;
        logic [CNT_W-1:0]         count;
    } t_cell_ctrl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [EXP_W-1:0]         exp;
        logic                     lt;
    } t_cell_link;

    // what a cell reports to the controller
    typedef struct packed {
        logic eq;
        logic del;
    } t_cell_match;

endpackage

/* rtl/sptt_if.sv */
// ============================================================================
// sptt_if
// Valid/ready channels of the term table: input words and result words.
// ============================================================================
interface sptt_in_if
    import sptt_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sptt_out_if
    import sptt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sptt_cell.sv */
// ============================================================================
// sptt_cell
// One slot of the sorted term chain: holds a term, compares it with an
// incoming exponent, and shifts or rotates with its neighbors.
// ============================================================================
module sptt_cell
    import sptt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [CNT_W-1:0] i_index,
    input  t_cell_ctrl  i_ctrl,
    input  t_cell_link  i_left,
    input  t_cell_link  i_right,
    input  t_cell_link  i_head,
    output t_cell_link  o_link,
    output t_cell_match o_match
);

    logic signed [COEF_W-1:0] r_coef, n_coef;
    logic [EXP_W-1:0]         r_exp, n_exp;
    logic signed [COEF_W-1:0] r_sum, n_sum;
    logic                     r_zero, n_zero;
    logic                     r_lt, n_lt;
    logic                     r_eq, n_eq;

    logic                     w_occ;
    logic                     w_last;
    logic [CNT_W-1:0]         w_count_m1;
    logic signed [COEF_W:0]   w_sum_wide;
    logic signed [COEF_W-1:0] w_sum_sat;

    assign w_occ      = i_index < i_ctrl.count;
    assign w_count_m1 = i_ctrl.count - CNT_W'(1);
    assign w_last     = i_index == w_count_m1;

    // saturating add of the stored and the incoming coefficient
    assign w_sum_wide = {r_coef[COEF_W-1], r_coef} + {i_ctrl.coef[COEF_W-1], i_ctrl.coef};
    always_comb begin
        if (w_sum_wide[COEF_W] == w_sum_wide[COEF_W-1]) begin
            w_sum_sat = w_sum_wide[COEF_W-1:0];
        end else if (w_sum_wide[COEF_W]) begin
            w_sum_sat = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            w_sum_sat = {1'b0, {(COEF_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_coef = r_coef;
        n_exp  = r_exp;
        n_sum  = r_sum;
        n_zero = r_zero;
        n_lt   = r_lt;
        n_eq   = r_eq;
        case (i_ctrl.op)
            CELL_CAPTURE: begin
                n_lt   = w_occ && (r_exp < i_ctrl.exp);
                n_eq   = w_occ && (r_exp == i_ctrl.exp);
                n_sum  = w_sum_sat;
                n_zero = w_sum_sat == '0;
            end
            CELL_ADD_NEW: begin
                if (!r_lt) begin
                    if (i_left.lt) begin
                        n_coef = i_ctrl.coef;
                        n_exp  = i_ctrl.exp;
                    end else begin
                        n_coef = i_left.coef;
                        n_exp  = i_left.exp;
                    end
                end
            end
            CELL_MERGE: begin
                if (r_eq) begin
                    n_coef = r_sum;
                end
            end
            CELL_REMOVE: begin
                if (!r_lt) begin
                    n_coef = i_right.coef;
                    n_exp  = i_right.exp;
                end
            end
            CELL_ROTATE: begin
                if (w_last) begin
                    n_coef = i_head.coef;
                    n_exp  = i_head.exp;
                end else begin
                    n_coef = i_right.coef;
                    n_exp  = i_right.exp;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
        r_exp  <= n_exp;
        r_sum  <= n_sum;
        r_zero <= n_zero;
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
    end

    assign o_link.coef  = r_coef;
    assign o_link.exp   = r_exp;
    assign o_link.lt    = r_lt;
    assign o_match.eq   = r_eq;
    assign o_match.del  = r_eq && r_zero;

endmodule

/* rtl/sparse_polynomial_term_table.sv */
// ============================================================================
// sparse_polynomial_term_table
// Sorted table of polynomial terms with insert/merge, readout, derivative
// readout and clear.
// ============================================================================
// Terms live in a chain of MAX_TERMS cells, sorted by ascending exponent,
// cell 0 holding the lowest. In the accept cycle of an insert every cell
// compares its exponent and forms its saturated sum; in S_INSERT, once the
// output register is free, the chain shifts right to open a slot, shifts left
// to close one, updates the matching cell, or is left alone (zero coefficient,
// full table). Clear and an empty readout also wait for that register.
// A readout rotates the occupied cells one place per cycle while the readout
// stage can take a term and streams cell 0, one word per cycle when the sink
// keeps up; the derivative product is formed combinationally before the output
// register. A new input word is taken once the previous one is finished;
// its result may still wait in the output register.
// ============================================================================
module sparse_polynomial_term_table
    import sptt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    sptt_in_if.sink          i_in,
    sptt_out_if.source       o_out
);

    localparam int PROD_W = COEF_W + EXP_W + 1;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_left;
    logic signed [COEF_W-1:0] r_c;
    logic [EXP_W-1:0]         r_e;
    logic                     r_deriv;

    // readout stage between cell 0 and the output register
    logic                     r_s1_valid;
    logic signed [COEF_W-1:0] r_s1_coef;
    logic [EXP_W-1:0]         r_s1_exp;
    logic                     r_s1_last;
    logic                     r_s1_skip;

    logic                     r_out_valid;
    t_out_word                r_out, n_out;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_s1_move;
    logic                     w_fetch;
    logic                     w_load;
    t_cell_op                 w_op;
    t_cell_ctrl               w_ctrl;
    logic [MAX_TERMS-1:0]     w_eq;
    logic [MAX_TERMS-1:0]     w_del;
    logic                     w_any_eq;
    logic                     w_any_del;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [COEF_W-1:0] w_prod_sat;

    t_cell_link               w_link  [MAX_TERMS];
    t_cell_link               w_lnbr  [MAX_TERMS];
    t_cell_link               w_rnbr  [MAX_TERMS];
    t_cell_match              w_match [MAX_TERMS];

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = r_state == S_IDLE;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_move  = r_s1_valid && w_out_free;

    // ---- cell chain --------------------------------------------------------
    // In the accept cycle cells compare against the incoming word directly.
    assign w_ctrl.op    = w_op;
    assign w_ctrl.coef  = (r_state == S_IDLE) ? i_in.data.coefficient : r_c;
    assign w_ctrl.exp   = (r_state == S_IDLE) ? i_in.data.exponent : r_e;
    assign w_ctrl.count = r_count;

    genvar g;
    generate
        for (g = 0; g < MAX_TERMS; g++) begin : g_cell
            if (g == 0) begin : g_first
                // left of the first cell counts as "below" so it takes a new term
                assign w_lnbr[g] = '{coef: '0, exp: '0, lt: 1'b1};
            end else begin : g_mid
                assign w_lnbr[g] = w_link[g-1];
            end
            if (g == MAX_TERMS - 1) begin : g_end
                assign w_rnbr[g] = '0;
            end else begin : g_nxt
                assign w_rnbr[g] = w_link[g+1];
            end

            sptt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (CNT_W'(g)),
                .i_ctrl  (w_ctrl),
                .i_left  (w_lnbr[g]),
                .i_right (w_rnbr[g]),
                .i_head  (w_link[0]),
                .o_link  (w_link[g]),
                .o_match (w_match[g])
            );

            assign w_eq[g]  = w_match[g].eq;
            assign w_del[g] = w_match[g].del;
        end
    endgenerate

    assign w_any_eq  = |w_eq;
    assign w_any_del = |w_del;

    // ---- derivative product, saturated to the coefficient range -----------
    assign w_prod = r_s1_coef * $signed({1'b0, r_s1_exp});
    always_comb begin
        if (w_prod[PROD_W-1:COEF_W-1] == '0 || w_prod[PROD_W-1:COEF_W-1] == '1) begin
            w_prod_sat = w_prod[COEF_W-1:0];
        end else if (w_prod[PROD_W-1]) begin
            w_prod_sat = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            w_prod_sat = {1'b0, {(COEF_W-1){1'b1}}};
        end
    end

    // ---- next state --------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.data.mode)
                        MODE_INSERT: n_state = S_INSERT;
                        MODE_CLEAR:  n_state = S_CLEAR;
                        MODE_READ,
                        MODE_DERIV:  n_state = (r_count == '0) ? S_EMPTY : S_READ;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INSERT, S_CLEAR, S_EMPTY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (r_left == '0 && w_s1_move) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs of the controller -----------------------------------------
    always_comb begin
        w_op       = CELL_HOLD;
        w_load     = 1'b0;
        w_fetch    = 1'b0;
        n_count    = r_count;
        n_out      = '0;
        n_out.last = 1'b1;
        n_out.status = ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_op = CELL_CAPTURE;
                end
            end
            S_INSERT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (r_c == '0) begin
                        n_out.status = ST_DONE;
                    end else if (w_any_eq && w_any_del) begin
                        w_op         = CELL_REMOVE;
                        n_count      = r_count - CNT_W'(1);
                        n_out.status = ST_CANCELLED;
                    end else if (w_any_eq) begin
                        w_op         = CELL_MERGE;
                        n_out.status = ST_MERGED;
                    end else if (r_count == CNT_W'(MAX_TERMS)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_op         = CELL_ADD_NEW;
                        n_count      = r_count + CNT_W'(1);
                        n_out.status = ST_NEW;
                    end
                end
            end
            S_CLEAR: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_count = '0;
                end
            end
            S_EMPTY: begin
                w_load = w_out_free;
            end
            S_READ: begin
                w_fetch = (r_left != '0) && (!r_s1_valid || w_s1_move);
                if (w_fetch) begin
                    w_op = CELL_ROTATE;
                end
                // only the first term can have exponent zero; if it is also the
                // only term the derivative is empty
                if (w_s1_move && !(r_s1_skip && !r_s1_last)) begin
                    w_load     = 1'b1;
                    n_out.last = r_s1_last;
                    if (!r_s1_skip) begin
                        n_out.term_valid = 1'b1;
                        if (r_deriv) begin
                            n_out.coefficient_out = w_prod_sat;
                            n_out.exponent_out    = r_s1_exp - EXP_W'(1);
                        end else begin
                            n_out.coefficient_out = r_s1_coef;
                            n_out.exponent_out    = r_s1_exp;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.term_count = n_count;
    end

    // ---- registers ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_accept) begin
                r_left <= r_count;
            end else if (w_fetch) begin
                r_left <= r_left - CNT_W'(1);
            end
            if (w_fetch) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_c     <= i_in.data.coefficient;
            r_e     <= i_in.data.exponent;
            r_deriv <= i_in.data.mode == MODE_DERIV;
        end
        if (w_fetch) begin
            r_s1_coef <= w_link[0].coef;
            r_s1_exp  <= w_link[0].exp;
            r_s1_last <= r_left == CNT_W'(1);
            r_s1_skip <= r_deriv && (w_link[0].exp == '0);
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---- assertions --------------------------------------------------------
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_eq))
        else $error("more than one cell matched the exponent");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TERMS))
        else $error("term count beyond table size");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == CELL_ADD_NEW) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("new term did not grow the count");

    a_read_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_count == $past(r_count)))
        else $error("readout changed the term count");

    a_fetch_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fetch |-> (r_state == S_READ && r_count != '0))
        else $error("rotation outside a readout");

endmodule
